FILE: hdl/ssfa_pkg.sv
`timescale 1ns / 1ps

package ssfa_pkg;

   // field widths
   localparam int BLK_W    = 31;
   localparam int STRIPE_W = 21;
   localparam int DCNT_W   = 4;
   localparam int CNT_W    = 32;
   localparam int IDX_W    = 3;
   localparam int CMD_W    = 2;
   localparam int STS_W    = 2;

   // device storage
   localparam int MAX_DEVICES = 8;
   localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int NDW   = ($clog2(MAX_DEVICES + 1) > DCNT_W) ?
                          $clog2(MAX_DEVICES + 1) : DCNT_W;

   // iterative divider
   localparam int DIV_STEPS = BLK_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   // csr
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int PROD_W = CNT_W + STRIPE_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_code_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 2'd0,
      STS_BAD_RANGE = 2'd1,
      STS_BAD_INDEX = 2'd2
   } sts_code_type;

   typedef enum logic [1:0] {
      DV_START = 2'd0,
      DV_END   = 2'd1,
      DV_MID   = 2'd2,
      DV_DEV   = 2'd3
   } div_sel_type;

   typedef enum logic [2:0] {
      CR_NONE   = 3'd0,
      CR_SINGLE = 3'd1,
      CR_HEAD   = 3'd2,
      CR_TAIL   = 3'd3,
      CR_MID    = 3'd4
   } credit_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV_S,
      ST_DIV_E,
      ST_DIV_MID,
      ST_DIV_DEV,
      ST_SINGLE,
      ST_HEAD,
      ST_TAIL,
      ST_MUL,
      ST_MADD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic           load;
      logic           total_add;
      logic           clear;
      logic           div_start;
      div_sel_type    start_sel;
      logic           div_cap;
      div_sel_type    cap_sel;
      credit_sel_type credit;
      logic           walk_init;
      logic           mul;
      logic           walk_step;
      logic           out_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         range_bad;
      logic         same_stripe;
      logic         div_done;
      logic         walk_last;
      logic         out_free;
   } dp_sts_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                input logic [CNT_W-1:0] amt);
      logic [CNT_W:0] sum;
      sum = {1'b0, acc} + {1'b0, amt};
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

FILE: hdl/ssfa_div.sv
`timescale 1ns / 1ps

module ssfa_div
   import ssfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [BLK_W-1:0]    dividend,
   input  logic [STRIPE_W-1:0] divisor,
   output logic                done,
   output logic [BLK_W-1:0]    quot,
   output logic [STRIPE_W-1:0] rem
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [BLK_W-1:0]    quot_ff, quot_in;
   logic [STRIPE_W-1:0] rem_ff, rem_in;
   logic [STRIPE_W-1:0] dvs_ff, dvs_in;
   logic [STRIPE_W:0]   shifted;
   logic [STRIPE_W+1:0] diff;

   // one restoring step per cycle
   assign shifted = {rem_ff, quot_ff[BLK_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[STRIPE_W+1]) begin
            rem_in  = diff[STRIPE_W-1:0];
            quot_in = {quot_ff[BLK_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[STRIPE_W-1:0];
            quot_in = {quot_ff[BLK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: hdl/ssfa_ctrl.sv
`timescale 1ns / 1ps

module ssfa_ctrl
   import ssfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.cmd) inside
               CMD_ADD: begin
                  if (sts.range_bad) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.total_add = 1'b1;
                     cmd.div_start = 1'b1;
                     cmd.start_sel = DV_START;
                     state_in      = ST_DIV_S;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end
               CMD_READ, CMD_NONE: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_DIV_S: begin
            if (sts.div_done) begin
               cmd.div_cap   = 1'b1;
               cmd.cap_sel   = DV_START;
               cmd.div_start = 1'b1;
               cmd.start_sel = DV_END;
               state_in      = ST_DIV_E;
            end
         end
         ST_DIV_E: begin
            if (sts.div_done) begin
               cmd.div_cap   = 1'b1;
               cmd.cap_sel   = DV_END;
               cmd.div_start = 1'b1;
               cmd.start_sel = DV_MID;
               state_in      = ST_DIV_MID;
            end
         end
         ST_DIV_MID: begin
            if (sts.div_done) begin
               cmd.div_cap   = 1'b1;
               cmd.cap_sel   = DV_MID;
               cmd.div_start = 1'b1;
               cmd.start_sel = DV_DEV;
               state_in      = ST_DIV_DEV;
            end
         end
         ST_DIV_DEV: begin
            if (sts.div_done) begin
               cmd.div_cap = 1'b1;
               cmd.cap_sel = DV_DEV;
               state_in    = sts.same_stripe ? ST_SINGLE : ST_HEAD;
            end
         end
         ST_SINGLE: begin
            cmd.credit = CR_SINGLE;
            state_in   = ST_FINISH;
         end
         ST_HEAD: begin
            cmd.credit = CR_HEAD;
            state_in   = ST_TAIL;
         end
         ST_TAIL: begin
            cmd.credit    = CR_TAIL;
            cmd.walk_init = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MADD;
         end
         ST_MADD: begin
            cmd.credit    = CR_MID;
            cmd.walk_step = 1'b1;
            state_in      = sts.walk_last ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/ssfa_dp.sv
`timescale 1ns / 1ps

module ssfa_dp
   import ssfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic [STRIPE_W-1:0] stripe_size,
   input  logic [DCNT_W-1:0]   device_count,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [BLK_W-1:0]    req_range_start,
   input  logic [BLK_W-1:0]    req_range_end,
   input  logic [IDX_W-1:0]    req_device_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CNT_W-1:0]    rsp_device_free,
   output logic [CNT_W-1:0]    rsp_free_sum,
   output logic [STS_W-1:0]    rsp_status
);

   cmd_code_type        cmd_ff;
   logic [BLK_W-1:0]    s_ff, e_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [STRIPE_W-1:0] sz_eff;
   logic [NDW-1:0]      nd_eff;
   logic [BLK_W-1:0]    first_ff, full_ff;
   logic [STRIPE_W-1:0] rs_ff, re_ff;
   logic                same_ff;
   logic [DEV_W-1:0]    rem_ff, dev0_ff, dev_ptr_ff, walk_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    cnt_ff [MAX_DEVICES];
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_dev_ff, rsp_tot_ff;
   sts_code_type        rsp_sts_ff;

   logic                div_start, div_done;
   logic [BLK_W-1:0]    div_dividend, div_quot;
   logic [STRIPE_W-1:0] div_divisor, div_rem;

   logic [CNT_W-1:0]    range_len, amt, cur, cnt_in;
   logic [DEV_W-1:0]    credit_dev, rd_addr, tail_dev;
   logic [CNT_W-1:0]    walk_n;
   logic                read_ok, credit_en;
   sts_code_type        result_sts;

   function automatic logic [DEV_W-1:0] mod_nd(input logic [NDW:0] v,
                                                input logic [NDW-1:0] n);
      logic [NDW:0] r;
      r = (v >= {1'b0, n}) ? v - {1'b0, n} : v;
      return r[DEV_W-1:0];
   endfunction

   // zero stripe size counts as one; device count clamped to 1..MAX_DEVICES
   assign sz_eff = (stripe_size == '0) ? STRIPE_W'(1) : stripe_size;
   always_comb begin
      if (device_count == '0) begin
         nd_eff = NDW'(1);
      end else if (32'(device_count) > MAX_DEVICES) begin
         nd_eff = NDW'(MAX_DEVICES);
      end else begin
         nd_eff = NDW'(device_count);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= cmd_code_type'(req_command);
         s_ff   <= req_range_start;
         e_ff   <= req_range_end;
         idx_ff <= req_device_index;
      end
   end

   assign range_len = {1'b0, e_ff} - {1'b0, s_ff} + CNT_W'(1);

   // divider operands
   assign div_start = cmd.div_start;
   always_comb begin
      unique case (cmd.start_sel)
         DV_START: begin
            div_dividend = s_ff;
            div_divisor  = sz_eff;
         end
         DV_END: begin
            div_dividend = e_ff;
            div_divisor  = sz_eff;
         end
         DV_MID: begin
            div_dividend = div_quot - first_ff - BLK_W'(1);
            div_divisor  = STRIPE_W'(nd_eff);
         end
         DV_DEV: begin
            div_dividend = first_ff;
            div_divisor  = STRIPE_W'(nd_eff);
         end
      endcase
   end

   ssfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_cap) begin
         unique case (cmd.cap_sel)
            DV_START: begin
               first_ff <= div_quot;
               rs_ff    <= div_rem;
            end
            DV_END: begin
               re_ff   <= div_rem;
               same_ff <= (div_quot == first_ff);
            end
            DV_MID: begin
               full_ff <= div_quot;
               rem_ff  <= div_rem[DEV_W-1:0];
            end
            DV_DEV: begin
               dev0_ff <= div_rem[DEV_W-1:0];
            end
         endcase
      end
   end

   // round-robin walk over the whole stripes
   assign tail_dev = mod_nd((NDW+1)'(dev0_ff) + (NDW+1)'(rem_ff) + (NDW+1)'(1), nd_eff);
   assign walk_n   = CNT_W'(full_ff) +
                     ((NDW'(walk_ff) < NDW'(rem_ff)) ? CNT_W'(1) : CNT_W'(0));

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         walk_ff    <= '0;
         dev_ptr_ff <= mod_nd((NDW+1)'(dev0_ff) + (NDW+1)'(1), nd_eff);
      end else if (cmd.walk_step) begin
         walk_ff    <= walk_ff + DEV_W'(1);
         dev_ptr_ff <= mod_nd((NDW+1)'(dev_ptr_ff) + (NDW+1)'(1), nd_eff);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(walk_n) * PROD_W'(sz_eff);
      end
   end

   // credit amount and target device
   always_comb begin
      credit_en  = 1'b1;
      amt        = '0;
      credit_dev = dev0_ff;
      case (cmd.credit)
         CR_SINGLE: amt = range_len;
         CR_HEAD:   amt = CNT_W'(sz_eff - rs_ff);
         CR_TAIL: begin
            amt        = CNT_W'(re_ff) + CNT_W'(1);
            credit_dev = tail_dev;
         end
         CR_MID: begin
            amt        = (prod_ff[PROD_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} :
                         prod_ff[CNT_W-1:0];
            credit_dev = dev_ptr_ff;
         end
         default: credit_en = 1'b0;
      endcase
   end

   assign rd_addr = credit_en ? credit_dev : DEV_W'(idx_ff);
   assign cur     = cnt_ff[rd_addr];
   assign cnt_in  = sat_add(cur, amt);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_DEVICES; i++) begin
            cnt_ff[i] <= '0;
         end
         total_ff <= '0;
      end else begin
         if (credit_en) begin
            cnt_ff[rd_addr] <= cnt_in;
         end
         if (cmd.total_add) begin
            total_ff <= sat_add(total_ff, range_len);
         end
      end
   end

   // result
   assign read_ok = (cmd_ff == CMD_READ) && (NDW'(idx_ff) < nd_eff);
   always_comb begin
      result_sts = STS_OK;
      if (cmd_ff == CMD_ADD && e_ff < s_ff) begin
         result_sts = STS_BAD_RANGE;
      end else if (cmd_ff == CMD_READ && !read_ok) begin
         result_sts = STS_BAD_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_dev_ff <= read_ok ? cur : '0;
         rsp_tot_ff <= total_ff;
         rsp_sts_ff <= result_sts;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_device_free = rsp_dev_ff;
   assign rsp_free_sum    = rsp_tot_ff;
   assign rsp_status      = rsp_sts_ff;

   assign sts.cmd         = cmd_ff;
   assign sts.range_bad   = (e_ff < s_ff);
   assign sts.same_stripe = same_ff;
   assign sts.div_done    = div_done;
   assign sts.walk_last   = ((NDW'(walk_ff) + NDW'(1)) == nd_eff);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hdl/striped_swap_free_accumulator.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  command, range_start, range_end, device_index
// rsp      out        rsp_valid / rsp_stall  device_free, free_sum, status
// csr      in/out     csr_psel / csr_penable stripe_size @0x0, device_count @0x4
//
// read, clear and unused commands: dispatch goes straight to finish, which loads the result register
// add: four divider passes (range start, range end, middle stripes, first device), then in one stripe
//    a single credit; across stripes a head and a tail credit, then a multiply and credit per device in use
// reset clears the counters, the running total and the result valid flag at once
// one transaction in the sequencer at a time; a stalled result holds its register, and the
//    next transaction waits in finish until the result has a slot

module striped_swap_free_accumulator
   import ssfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [BLK_W-1:0]    req_range_start,
   input  logic [BLK_W-1:0]    req_range_end,
   input  logic [IDX_W-1:0]    req_device_index,
   // response
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CNT_W-1:0]    rsp_device_free,
   output logic [CNT_W-1:0]    rsp_free_sum,
   output logic [STS_W-1:0]    rsp_status,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   // register map, selected by address bit 2
   localparam logic REG_STRIPE  = 1'b0;
   localparam logic REG_DEVICES = 1'b1;

   logic [STRIPE_W-1:0] stripe_ff;
   logic [DCNT_W-1:0]   devcnt_ff;
   logic                csr_wr;
   dp_cmd_type          cmd;
   dp_sts_type          sts;

   // register port: pready is always high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stripe_ff <= STRIPE_W'(2048);
         devcnt_ff <= DCNT_W'(1);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_STRIPE:  stripe_ff <= csr_pwdata[STRIPE_W-1:0];
            REG_DEVICES: devcnt_ff <= csr_pwdata[DCNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_STRIPE:  csr_prdata = CSR_DW'(stripe_ff);
         REG_DEVICES: csr_prdata = CSR_DW'(devcnt_ff);
      endcase
   end

   // sequencer
   ssfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, divider, stripe walk and result register
   ssfa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .stripe_size      (stripe_ff),
      .device_count     (devcnt_ff),
      .req_command      (req_command),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .req_device_index (req_device_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_device_free  (rsp_device_free),
      .rsp_free_sum     (rsp_free_sum),
      .rsp_status       (rsp_status)
   );

   // an accepted transaction always takes the sequencer out of idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // a rejected read never reports a device count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_W'(STS_BAD_INDEX)) |-> (rsp_device_free == '0))
      else $error("bad index result carries a count");

   // a reversed range never reports a device count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_W'(STS_BAD_RANGE)) |-> (rsp_device_free == '0))
      else $error("bad range result carries a count");

endmodule
